### hw/rtl/oadf_pkg.sv
`default_nettype none

package oadf_pkg;

    localparam int DIST_W  = 13;
    localparam int TIME_W  = 16;
    localparam int ELAP_W  = 8;
    localparam int POWER_W = 7;
    localparam int DRIVE_W = 8;
    localparam int TURNS_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRONT_STOP    = 3'd0,
        REG_IR_STOP       = 3'd1,
        REG_MIN_TURN      = 3'd2,
        REG_FORWARD_CHECK = 3'd3,
        REG_BACKUP        = 3'd4,
        REG_TURN          = 3'd5,
        REG_LEFT_POWER    = 3'd6,
        REG_RIGHT_POWER   = 3'd7
    } cfg_reg_t;

    localparam logic [DIST_W-1:0]  FRONT_STOP_RST    = 13'd300;
    localparam logic [DIST_W-1:0]  IR_STOP_RST       = 13'd200;
    localparam logic [DIST_W-1:0]  MIN_TURN_RST      = 13'd130;
    localparam logic [TIME_W-1:0]  FORWARD_CHECK_RST = 16'd200;
    localparam logic [TIME_W-1:0]  BACKUP_RST        = 16'd600;
    localparam logic [TIME_W-1:0]  TURN_RST          = 16'd600;
    localparam logic [POWER_W-1:0] LEFT_POWER_RST    = 7'd35;
    localparam logic [POWER_W-1:0] RIGHT_POWER_RST   = 7'd30;

    localparam logic [TURNS_W-1:0] TURNS_MAX = 3'd7;

    typedef struct packed {
        logic [DIST_W-1:0] ir_right_mm;
        logic [DIST_W-1:0] ir_left_mm;
        logic [DIST_W-1:0] dist_right_mm;
        logic [DIST_W-1:0] dist_center_mm;
        logic [DIST_W-1:0] dist_left_mm;
        logic [ELAP_W-1:0] elapsed_ms;
        logic              restart;
    } in_item_t;

endpackage

`default_nettype wire

### hw/rtl/obstacle_avoid_drive_fsm_top.sv
`default_nettype none

// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   s_axis_tdata, 80 bits
// m_axis    out        m_axis_tvalid/m_axis_tready   m_axis_tdata, 24 bits
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One transaction per cycle is sustained while the output is not stalled: an
// accepted item is held in the input register, and the mode logic moves it to
// the output register. A stalled output holds the item in the input register,
// which takes a new item only while it is empty.
// Reset puts the machine in forward mode with the timer, counters and drives at
// zero and loads the register defaults. The configuration port is always ready.
module obstacle_avoid_drive_fsm_top #(
    parameter int TURN_LIMIT = 5
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // restart[0], elapsed_ms[8:1], dist_left_mm[21:9], dist_center_mm[34:22],
    // dist_right_mm[47:35], ir_left_mm[60:48], ir_right_mm[73:61], bits above ignored
    input  wire logic [oadf_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // mode[2:0], left_drive[10:3], right_drive[18:11], zeros above
    output logic [oadf_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [oadf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [oadf_pkg::CFG_DATA_W-1:0]       cfg_data
);

    typedef enum logic [2:0] {
        MODE_FWD    = 3'd0,
        MODE_BWD    = 3'd1,
        MODE_LEFT   = 3'd2,
        MODE_RIGHT  = 3'd3,
        MODE_CHOOSE = 3'd4
    } mode_t;

    localparam logic [4:0] LIMIT = 5'(TURN_LIMIT);

    logic [oadf_pkg::DIST_W-1:0]  front_stop_reg, ir_stop_reg, min_turn_reg;
    logic [oadf_pkg::TIME_W-1:0]  forward_check_reg, backup_reg, turn_reg;
    logic [oadf_pkg::POWER_W-1:0] left_power_reg, right_power_reg;

    logic                         in_valid_reg;
    oadf_pkg::in_item_t           in_item_reg;
    logic                         out_valid_reg;
    logic [oadf_pkg::OUT_TDATA_W-1:0] out_data_reg;

    mode_t                         mode_reg, mode_next;
    logic [oadf_pkg::TIME_W-1:0]   timer_reg, timer_next;
    logic [oadf_pkg::TURNS_W-1:0]  left_turns_reg, left_turns_next;
    logic [oadf_pkg::TURNS_W-1:0]  right_turns_reg, right_turns_next;
    logic [oadf_pkg::DRIVE_W-1:0]  left_motor_reg, left_motor_next;
    logic [oadf_pkg::DRIVE_W-1:0]  right_motor_reg, right_motor_next;

    logic                          advance;
    logic [oadf_pkg::TIME_W:0]     timer_sum;
    logic [oadf_pkg::TIME_W-1:0]   timer_sat;
    logic                          blocked;
    logic                          too_close;
    logic                          turns_over;
    logic [oadf_pkg::DRIVE_W-1:0]  left_pos, left_neg, right_pos, right_neg;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    assign left_pos  = {1'b0, left_power_reg};
    assign right_pos = {1'b0, right_power_reg};
    assign left_neg  = 8'(-{1'b0, left_power_reg});
    assign right_neg = 8'(-{1'b0, right_power_reg});

    always_comb
    begin
        timer_sum = {1'b0, timer_reg} + 17'(in_item_reg.elapsed_ms);
        timer_sat = timer_sum[oadf_pkg::TIME_W] ? '1 : timer_sum[oadf_pkg::TIME_W-1:0];

        blocked = (in_item_reg.dist_center_mm < front_stop_reg)
               || (in_item_reg.dist_left_mm < front_stop_reg)
               || (in_item_reg.dist_right_mm < front_stop_reg)
               || (in_item_reg.ir_left_mm < ir_stop_reg)
               || (in_item_reg.ir_right_mm < ir_stop_reg);

        too_close = (in_item_reg.dist_center_mm < min_turn_reg)
                 || (in_item_reg.ir_left_mm < min_turn_reg)
                 || (in_item_reg.ir_right_mm < min_turn_reg)
                 || ((in_item_reg.dist_left_mm < min_turn_reg)
                     && (in_item_reg.dist_right_mm < min_turn_reg));

        turns_over = ({2'b00, right_turns_reg} > LIMIT) || ({2'b00, left_turns_reg} > LIMIT);

        mode_next        = mode_reg;
        timer_next       = timer_sat;
        left_turns_next  = left_turns_reg;
        right_turns_next = right_turns_reg;
        left_motor_next  = left_motor_reg;
        right_motor_next = right_motor_reg;

        if (in_item_reg.restart)
        begin
            mode_next        = MODE_FWD;
            left_turns_next  = '0;
            right_turns_next = '0;
            left_motor_next  = '0;
            right_motor_next = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_FWD:
                begin
                    left_motor_next  = left_pos;
                    right_motor_next = right_pos;
                    if (timer_sat >= forward_check_reg)
                    begin
                        timer_next = '0;
                        if (blocked)
                        begin
                            left_motor_next  = '0;
                            right_motor_next = '0;
                            mode_next        = MODE_CHOOSE;
                        end
                    end
                end
                MODE_BWD:
                begin
                    if (timer_sat >= backup_reg)
                    begin
                        timer_next       = '0;
                        left_motor_next  = '0;
                        right_motor_next = '0;
                        mode_next        = MODE_CHOOSE;
                    end
                    else
                    begin
                        left_motor_next  = left_neg;
                        right_motor_next = right_neg;
                    end
                end
                MODE_LEFT, MODE_RIGHT:
                begin
                    if (timer_sat >= turn_reg)
                    begin
                        timer_next = '0;
                        if (blocked)
                        begin
                            left_motor_next  = '0;
                            right_motor_next = '0;
                            mode_next        = MODE_CHOOSE;
                        end
                        else
                        begin
                            mode_next = MODE_FWD;
                        end
                    end
                    else if (mode_reg == MODE_LEFT)
                    begin
                        left_motor_next  = left_neg;
                        right_motor_next = right_pos;
                    end
                    else
                    begin
                        left_motor_next  = left_pos;
                        right_motor_next = right_neg;
                    end
                end
                MODE_CHOOSE:
                begin
                    timer_next = '0;
                    if (turns_over)
                    begin
                        left_turns_next  = '0;
                        right_turns_next = '0;
                        mode_next        = MODE_BWD;
                    end
                    else if (too_close)
                    begin
                        mode_next = MODE_BWD;
                    end
                    else if (in_item_reg.dist_left_mm >= in_item_reg.dist_right_mm)
                    begin
                        mode_next = MODE_LEFT;
                        if (left_turns_reg != oadf_pkg::TURNS_MAX)
                        begin
                            left_turns_next = left_turns_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        mode_next = MODE_RIGHT;
                        if (right_turns_reg != oadf_pkg::TURNS_MAX)
                        begin
                            right_turns_next = right_turns_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    mode_next        = MODE_FWD;
                    left_turns_next  = '0;
                    right_turns_next = '0;
                    left_motor_next  = '0;
                    right_motor_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_stop_reg    <= oadf_pkg::FRONT_STOP_RST;
            ir_stop_reg       <= oadf_pkg::IR_STOP_RST;
            min_turn_reg      <= oadf_pkg::MIN_TURN_RST;
            forward_check_reg <= oadf_pkg::FORWARD_CHECK_RST;
            backup_reg        <= oadf_pkg::BACKUP_RST;
            turn_reg          <= oadf_pkg::TURN_RST;
            left_power_reg    <= oadf_pkg::LEFT_POWER_RST;
            right_power_reg   <= oadf_pkg::RIGHT_POWER_RST;
        end
        else if (cfg_valid)
        begin
            case (oadf_pkg::cfg_reg_t'(cfg_index))
                oadf_pkg::REG_FRONT_STOP:    front_stop_reg    <= cfg_data[oadf_pkg::DIST_W-1:0];
                oadf_pkg::REG_IR_STOP:       ir_stop_reg       <= cfg_data[oadf_pkg::DIST_W-1:0];
                oadf_pkg::REG_MIN_TURN:      min_turn_reg      <= cfg_data[oadf_pkg::DIST_W-1:0];
                oadf_pkg::REG_FORWARD_CHECK: forward_check_reg <= cfg_data;
                oadf_pkg::REG_BACKUP:        backup_reg        <= cfg_data;
                oadf_pkg::REG_TURN:          turn_reg          <= cfg_data;
                oadf_pkg::REG_LEFT_POWER:    left_power_reg    <= cfg_data[oadf_pkg::POWER_W-1:0];
                oadf_pkg::REG_RIGHT_POWER:   right_power_reg   <= cfg_data[oadf_pkg::POWER_W-1:0];
                default:                     front_stop_reg    <= front_stop_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            mode_reg        <= MODE_FWD;
            timer_reg       <= '0;
            left_turns_reg  <= '0;
            right_turns_reg <= '0;
            left_motor_reg  <= '0;
            right_motor_reg <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                mode_reg        <= mode_next;
                timer_reg       <= timer_next;
                left_turns_reg  <= left_turns_next;
                right_turns_reg <= right_turns_next;
                left_motor_reg  <= left_motor_next;
                right_motor_reg <= right_motor_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= oadf_pkg::in_item_t'(s_axis_tdata[$bits(oadf_pkg::in_item_t)-1:0]);
        end
        if (advance)
        begin
            out_data_reg <= {5'b00000, right_motor_next, left_motor_next, mode_next};
        end
    end

endmodule

`default_nettype wire
